@@ sv/fixed_width_decimal_digits_defines.svh @@
// assertion macros for the decimal digit emitter
`ifndef FIXED_WIDTH_DECIMAL_DIGITS_DEFINES_SVH
`define FIXED_WIDTH_DECIMAL_DIGITS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FWDD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fwdd check failed");

// next-cycle implication, checked out of reset
`define FWDD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fwdd check failed");

`endif

@@ sv/fwdd_pkg.sv @@
// shared types and constants for the decimal digit emitter
package fwdd_pkg;

    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 4;
    localparam int CHAR_W    = 6;
    localparam int DIGIT_W   = 4;
    localparam int BIT_CNT_W = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0]    ASCII_ZERO = 6'd48;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(VALUE_W - 1);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] digit_count;
        logic               invert_flag;
    } t_req;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              invert_out;
        logic              last_digit;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    // sequencer to datapath controls
    typedef struct packed {
        logic load;
        logic shift;
        logic emit_start;
    } t_ctl;

    // emitter status back to the sequencer
    typedef struct packed {
        logic active;
        logic on_last;
    } t_emit_sts;

endpackage

@@ sv/fixed_width_decimal_digits.sv @@
// top level of the fixed-width decimal digit emitter
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------
//  request  | start / busy       | i_req : value, digit_count, invert_flag
//  result   | o_strobe (1 cycle) | o_res : digit_char, invert_out, last_digit
//
// a request with a nonzero count first runs bit-serial bcd conversion
// (one value bit per cycle through the shift-and-add-three register), then
// emits its digits, top requested one first; busy is high in both states.
// a count of zero emits nothing and busy never rises.
// reset is synchronous and active low; it clears the sequencer and the strobe.
// results cannot be stalled: each digit is flagged by o_strobe for exactly one cycle.
module fixed_width_decimal_digits
    import fwdd_pkg::*;
#(
    parameter int MAX_DIGITS = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_res o_res
);

    `include "fixed_width_decimal_digits_defines.svh"

    t_state                      r_state;
    t_state                      n_state;
    logic [BIT_CNT_W-1:0]        r_bit_cnt;
    logic [BIT_CNT_W-1:0]        n_bit_cnt;
    logic [COUNT_W-1:0]          r_cnt;
    logic [COUNT_W-1:0]          n_cnt;
    logic                        r_inv;
    logic                        n_inv;
    logic [COUNT_W-1:0]          clamped;
    logic                        accept;
    t_ctl                        ctl;
    t_emit_sts                   emit_sts;
    logic [MAX_DIGITS*DIGIT_W-1:0] bcd;

    assign accept  = start && !busy;
    assign clamped = (i_req.digit_count > COUNT_W'(MAX_DIGITS)) ?
                     COUNT_W'(MAX_DIGITS) : i_req.digit_count;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && clamped != '0) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_bit_cnt == LAST_BIT) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_sts.on_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        busy           = 1'b0;
        ctl.load       = 1'b0;
        ctl.shift      = 1'b0;
        ctl.emit_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                ctl.load = accept;
            end
            ST_CONV: begin
                busy           = 1'b1;
                ctl.shift      = 1'b1;
                ctl.emit_start = (r_bit_cnt == LAST_BIT);
            end
            ST_EMIT: begin
                busy = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    // request capture and bit counter
    always_comb begin
        n_cnt     = r_cnt;
        n_inv     = r_inv;
        n_bit_cnt = r_bit_cnt;
        if (ctl.load) begin
            n_cnt     = clamped;
            n_inv     = i_req.invert_flag;
            n_bit_cnt = '0;
        end else if (ctl.shift) begin
            n_bit_cnt = r_bit_cnt + BIT_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bit_cnt <= n_bit_cnt;
        r_cnt     <= n_cnt;
        r_inv     <= n_inv;
    end

    fwdd_dabble #(
        .NDIG (MAX_DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_value (i_req.value),
        .o_bcd   (bcd)
    );

    fwdd_emit #(
        .NDIG (MAX_DIGITS)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_count  (r_cnt),
        .i_inv    (r_inv),
        .i_bcd    (bcd),
        .o_sts    (emit_sts),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    // checks
    `FWDD_ASSERT_NXT(a_accept_converts, accept && clamped != '0, r_state == ST_CONV)
    `FWDD_ASSERT_NXT(a_conv_to_emit, r_state == ST_CONV && r_bit_cnt == LAST_BIT, emit_sts.active)
    `FWDD_ASSERT_NXT(a_last_ends_run, o_strobe && o_res.last_digit, !o_strobe)
    `FWDD_ASSERT_IMP(a_no_digit_in_conv, o_strobe, r_state != ST_CONV)

endmodule

@@ sv/fwdd_dabble.sv @@
// bit-serial binary to bcd converter (shift and add three)
module fwdd_dabble
    import fwdd_pkg::*;
#(
    parameter int NDIG = 10
) (
    input  logic                    i_clk,
    input  t_ctl                    i_ctl,
    input  logic [VALUE_W-1:0]      i_value,
    output logic [NDIG*DIGIT_W-1:0] o_bcd
);

    logic [VALUE_W-1:0]      r_bin;
    logic [NDIG*DIGIT_W-1:0] r_bcd;
    logic [VALUE_W-1:0]      n_bin;
    logic [NDIG*DIGIT_W-1:0] n_bcd;
    logic [NDIG*DIGIT_W-1:0] adj;

    // add three to every digit of five or more before doubling
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
            end else begin
                adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // load, or shift one binary bit into the bcd word; top carry drops out
    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_ctl.load) begin
            n_bin = i_value;
            n_bcd = '0;
        end else if (i_ctl.shift) begin
            n_bin = {r_bin[VALUE_W-2:0], 1'b0};
            n_bcd = {adj[NDIG*DIGIT_W-2:0], r_bin[VALUE_W-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_bcd = r_bcd;

endmodule

@@ sv/fwdd_emit.sv @@
// walks the bcd digits from the top requested one down, one per cycle
module fwdd_emit
    import fwdd_pkg::*;
#(
    parameter int NDIG = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic [COUNT_W-1:0]      i_count,
    input  logic                    i_inv,
    input  logic [NDIG*DIGIT_W-1:0] i_bcd,
    output t_emit_sts               o_sts,
    output logic                    o_strobe,
    output t_res                    o_res
);

    localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic               r_active;
    logic               n_active;
    logic               r_strobe;
    logic               n_strobe;
    t_res               r_res;
    t_res               n_res;
    logic [DIGIT_W-1:0] digit;

    assign digit = i_bcd[DIGIT_W*r_idx +: DIGIT_W];

    // index countdown and result formatting
    always_comb begin
        n_idx    = r_idx;
        n_active = r_active;
        n_strobe = 1'b0;
        n_res    = r_res;
        if (i_ctl.emit_start) begin
            n_idx    = IDX_W'(i_count - COUNT_W'(1));
            n_active = 1'b1;
        end else if (r_active) begin
            n_strobe         = 1'b1;
            n_res.digit_char = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
            n_res.invert_out = i_inv;
            n_res.last_digit = (r_idx == '0);
            if (r_idx == '0) begin
                n_active = 1'b0;
            end else begin
                n_idx = r_idx - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_active <= n_active;
            r_strobe <= n_strobe;
        end
        r_idx <= n_idx;
        r_res <= n_res;
    end

    assign o_sts.active  = r_active;
    assign o_sts.on_last = r_active && (r_idx == '0);
    assign o_strobe      = r_strobe;
    assign o_res         = r_res;

endmodule
